### hdl/atu_pkg.sv
// shared types, constants and character codes of the ascii to unsigned parser
`default_nettype none
package atu_pkg;

	// result and counter geometry
	localparam int VALUE_BITS = 64;
	localparam int MAX_CHARS  = 4096;
	localparam int CNT_BITS   = 12;
	localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_CHARS - 1);
	localparam int PROD_BITS  = VALUE_BITS + 6;

	// base and digit codes
	localparam int BASE_BITS  = 6;
	localparam int DIGIT_BITS = 6;
	localparam logic [BASE_BITS-1:0]  BASE_RESET = 6'd16;
	localparam logic [BASE_BITS-1:0]  BASE_AUTO  = 6'd0;
	localparam logic [BASE_BITS-1:0]  BASE_MIN   = 6'd2;
	localparam logic [BASE_BITS-1:0]  BASE_MAX   = 6'd36;
	localparam logic [BASE_BITS-1:0]  BASE_OCT   = 6'd8;
	localparam logic [BASE_BITS-1:0]  BASE_DEC   = 6'd10;
	localparam logic [BASE_BITS-1:0]  BASE_HEX   = 6'd16;
	localparam logic [DIGIT_BITS-1:0] NO_DIGIT   = '1;
	localparam logic [DIGIT_BITS-1:0] DIGIT_ZERO = '0;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] UC_LETTER_BASE = CH_UA - 8'd10;
	localparam logic [7:0] LC_LETTER_BASE = CH_LA - 8'd10;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// classified character
	typedef struct packed {
		logic [DIGIT_BITS-1:0] dig;
		logic                  space;
		logic                  minus;
		logic                  plus;
		logic                  xchar;
		logic                  last;
	} item_t;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_NONE,
		ST_SOME,
		ST_OVER
	} status_t;

	// parse state captured at the end of a string
	typedef struct packed {
		logic [VALUE_BITS-1:0] acc;
		logic                  neg;
		status_t               status;
		logic [CNT_BITS-1:0]   cnt;
	} raw_t;

endpackage
`default_nettype wire

### hdl/atu_ifs.sv
// channel interfaces of the ascii to unsigned parser
`default_nettype none

// character channel
interface atu_char_if ();
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;
	modport source (output valid, character, last, input ready);
	modport sink (input valid, character, last, output ready);
endinterface

// result channel
interface atu_res_if import atu_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic [CNT_BITS-1:0]   end_offset;
	logic                  overflowed;
	logic                  digits_seen;
	modport source (output valid, value, end_offset, overflowed, digits_seen, input ready);
	modport sink (input valid, value, end_offset, overflowed, digits_seen, output ready);
endinterface

// base register write channel
interface atu_cfg_if import atu_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [BASE_BITS-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### hdl/ascii_to_unsigned_parser.sv
// ascii_to_unsigned_parser: streaming text to unsigned integer converter
// Characters enter on chr, one per transaction; last marks the final byte
// of a string. Each string gives exactly one transaction on res carrying the
// value, the end offset, the overflow flag and the digits-seen flag.
// cfg writes the 6-bit base register (0 = auto octal/decimal/hex, reset 16);
// it is always ready and is meant to be written while no string is pending.
// Throughput: one character per cycle, sustained, for any mix of strings, while res is ready.
// The rate is set by the back stage, which does one 64x6 multiply-add and
// range check per cycle on the accumulator loop.
// A last character, once transferred, passes through the front register,
// which loads on that transfer, then the queue, the raw result register and
// the output register before the result is valid.
// Reset clears the parse state, the queue and the result valid flags and sets
// the base register to 16; chr is ready while reset is held and after it.
// When the receiver stalls, the result holds; one more finished string is
// parked behind it and the queue keeps taking characters until it fills,
// after which chr deasserts ready.
`default_nettype none
module ascii_to_unsigned_parser import atu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	atu_char_if.sink  chr,
	atu_cfg_if.sink   cfg,
	atu_res_if.source res
);

	logic [BASE_BITS-1:0] base_q;
	item_t                front_item;
	logic                 front_valid;
	logic                 queue_ready;
	item_t                back_item;
	logic                 back_valid;
	logic                 back_ready;

	// base register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			base_q <= cfg.data;
		end
	end

	// front: accept and classify
	atu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.chr           (chr),
		.item_s1       (front_item),
		.item_valid_s1 (front_valid),
		.item_ready    (queue_ready)
	);

	// queue between front and back
	atu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (front_item),
		.wr_valid (front_valid),
		.wr_ready (queue_ready),
		.rd_item  (back_item),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	// back: parse and report
	atu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.base_select (base_q),
		.item        (back_item),
		.item_valid  (back_valid),
		.item_ready  (back_ready),
		.res         (res)
	);

`ifndef SYNTH
	// saturated results are all ones and always count as digits seen
	a_ovf_value: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.overflowed |-> (res.value == '1) && res.digits_seen)
		else $error("overflowed result is not saturated");

	// a string without digits reports zero everywhere
	a_no_digits: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.digits_seen |->
			(res.value == '0) && (res.end_offset == '0) && !res.overflowed)
		else $error("result without digits carries data");

	// front item holds while the queue is full
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid && !queue_ready |=> front_valid && $stable(front_item))
		else $error("front item changed while queue was full");
`endif

endmodule
`default_nettype wire

### hdl/atu_front.sv
// front stage: accepts characters and classifies them into queue items
`default_nettype none
module atu_front import atu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	atu_char_if.sink  chr,
	output item_t     item_s1,
	output logic      item_valid_s1,
	input  wire logic item_ready
);

	item_t item_c;
	logic  [7:0] c;

	assign c = chr.character;

	// character classification
	always_comb begin
		item_c.space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		item_c.minus = (c == CH_MINUS);
		item_c.plus  = (c == CH_PLUS);
		item_c.xchar = (c == CH_LX) || (c == CH_UX);
		item_c.last  = chr.last;
		priority if (c >= CH_0 && c <= CH_9) begin
			item_c.dig = DIGIT_BITS'(c - CH_0);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			item_c.dig = DIGIT_BITS'(c - UC_LETTER_BASE);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			item_c.dig = DIGIT_BITS'(c - LC_LETTER_BASE);
		end else begin
			item_c.dig = NO_DIGIT;
		end
	end

	// stage register, refilled whenever the queue takes the held item
	assign chr.ready = !item_valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (chr.ready) begin
			item_valid_s1 <= chr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chr.valid && chr.ready) begin
			item_s1 <= item_c;
		end
	end

endmodule
`default_nettype wire

### hdl/atu_queue.sv
// short first-in first-out queue of classified items
`default_nettype none
module atu_queue import atu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t wr_item,
	input  wire logic  wr_valid,
	output logic       wr_ready,
	output item_t      rd_item,
	output logic       rd_valid,
	input  wire logic  rd_ready
);

	item_t                slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule
`default_nettype wire

### hdl/atu_back.sv
// back stage: parse state machine, digit accumulation and result registers
`default_nettype none
module atu_back import atu_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [BASE_BITS-1:0] base_select,
	input  wire item_t                item,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	atu_res_if.source                 res
);

	phase_t                ph_q, ph_n;
	status_t               st_q, st_n, dig_st, st_fin;
	logic [VALUE_BITS-1:0] acc_q, acc_n;
	logic                  neg_q, neg_n;
	logic [BASE_BITS-1:0]  ab_q, ab_n;
	logic [CNT_BITS-1:0]   cnt_q, cnt_n;

	logic                  first_go;
	logic                  zero_prefix;
	logic [BASE_BITS-1:0]  first_base;
	logic [BASE_BITS-1:0]  zero_base;
	logic [BASE_BITS-1:0]  dig_base;
	logic [PROD_BITS-1:0]  sum;
	logic                  ovf;
	logic                  run_digit;

	raw_t                  raw_c;
	raw_t                  raw_s1;
	logic                  valid_s1;
	logic                  out_free;
	logic                  s1_free;
	logic                  take;

	// handshake toward the queue and the result register pair
	assign out_free   = !res.valid || res.ready;
	assign s1_free    = !valid_s1 || out_free;
	assign item_ready = !item.last || s1_free;
	assign take       = item_valid && item_ready;

	// base used for this character
	always_comb begin
		first_go    = (ph_q == PH_SIGNED) ||
			((ph_q == PH_SKIP) && !item.space && !item.minus && !item.plus);
		zero_prefix = ((base_select == BASE_AUTO) || (base_select == BASE_HEX)) &&
			(item.dig == DIGIT_ZERO);
		first_base  = (base_select == BASE_AUTO) ? BASE_DEC : base_select;
		zero_base   = (ab_q == BASE_AUTO) ? BASE_OCT : BASE_HEX;
		priority if (ph_q == PH_ZERO) begin
			dig_base = zero_base;
		end else if (first_go) begin
			dig_base = first_base;
		end else begin
			dig_base = ab_q;
		end
	end

	// multiply-add and range check
	assign sum = PROD_BITS'(acc_q) * PROD_BITS'(dig_base) + PROD_BITS'(item.dig);
	assign ovf = |sum[PROD_BITS-1:VALUE_BITS];

	// next parse state
	always_comb begin
		ph_n      = ph_q;
		st_n      = st_q;
		acc_n     = acc_q;
		neg_n     = neg_q;
		ab_n      = ab_q;
		dig_st    = st_q;
		run_digit = 1'b0;
		unique case (ph_q)
			PH_SKIP: begin
				priority if (item.space) begin
					ph_n = PH_SKIP;
				end else if (item.minus) begin
					neg_n = 1'b1;
					ph_n  = PH_SIGNED;
				end else if (item.plus) begin
					ph_n = PH_SIGNED;
				end else begin
					ph_n = PH_SKIP;
				end
			end
			PH_SIGNED: begin
				ph_n = PH_SIGNED;
			end
			PH_ZERO: begin
				ph_n = PH_DIGITS;
				if (item.xchar) begin
					ab_n = BASE_HEX;
				end else begin
					ab_n      = zero_base;
					st_n      = ST_SOME;
					dig_st    = ST_SOME;
					run_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				run_digit = 1'b1;
			end
			PH_DONE: begin
				ph_n = PH_DONE;
			end
			default: begin
				ph_n = PH_DONE;
			end
		endcase

		// first character after white space and sign
		if (first_go) begin
			if (zero_prefix) begin
				ab_n = base_select;
				ph_n = PH_ZERO;
			end else begin
				ab_n      = first_base;
				ph_n      = PH_DIGITS;
				run_digit = 1'b1;
			end
		end

		// digit acceptance
		if (run_digit) begin
			priority if (dig_base < BASE_MIN || dig_base > BASE_MAX ||
					DIGIT_BITS'(item.dig) >= dig_base) begin
				ph_n = PH_DONE;
			end else if (dig_st == ST_OVER) begin
				st_n = ST_OVER;
			end else if (ovf) begin
				st_n = ST_OVER;
			end else begin
				acc_n = sum[VALUE_BITS-1:0];
				st_n  = ST_SOME;
			end
		end

		// consumed character count
		cnt_n = cnt_q;
		if (ph_q != PH_DONE && ph_n != PH_DONE && cnt_q < CNT_MAX) begin
			cnt_n = cnt_q + 1'b1;
		end

		// end of string acts like a trailing nul byte
		st_fin = (ph_n == PH_ZERO) ? ST_SOME : st_n;

		raw_c.acc    = acc_n;
		raw_c.neg    = neg_n;
		raw_c.status = st_fin;
		raw_c.cnt    = cnt_n;
	end

	// parse state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_SKIP;
			st_q  <= ST_NONE;
			acc_q <= '0;
			neg_q <= 1'b0;
			ab_q  <= '0;
			cnt_q <= '0;
		end else if (take) begin
			if (item.last) begin
				ph_q  <= PH_SKIP;
				st_q  <= ST_NONE;
				acc_q <= '0;
				neg_q <= 1'b0;
				ab_q  <= '0;
				cnt_q <= '0;
			end else begin
				ph_q  <= ph_n;
				st_q  <= st_n;
				acc_q <= acc_n;
				neg_q <= neg_n;
				ab_q  <= ab_n;
				cnt_q <= cnt_n;
			end
		end
	end

	// result pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			res.valid <= 1'b0;
		end else begin
			if (take && item.last) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				res.valid <= valid_s1;
			end
		end
	end

	// result payload: raw capture, then sign and saturation
	always_ff @(posedge clk) begin
		if (take && item.last) begin
			raw_s1 <= raw_c;
		end
		if (out_free && valid_s1) begin
			priority if (raw_s1.status == ST_OVER) begin
				res.value <= '1;
			end else if (raw_s1.neg) begin
				res.value <= '0 - raw_s1.acc;
			end else begin
				res.value <= raw_s1.acc;
			end
			res.end_offset  <= (raw_s1.status != ST_NONE) ? raw_s1.cnt : '0;
			res.overflowed  <= (raw_s1.status == ST_OVER);
			res.digits_seen <= (raw_s1.status != ST_NONE);
		end
	end

endmodule
`default_nettype wire
